>>> design/tan_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tan_pkg
// Shared types and constants for the triangle area and normal block.
// ----------------------------------------------------------------------------
package tan_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_EDGE,
    S_MUL,
    S_SQRT,
    S_DIV,
    S_OUT
  } state_t;

  // multiply sequence: cross product terms, then squares of each component
  localparam logic [3:0] OP_C0P  = 4'd0;
  localparam logic [3:0] OP_C0N  = 4'd1;
  localparam logic [3:0] OP_C1P  = 4'd2;
  localparam logic [3:0] OP_C1N  = 4'd3;
  localparam logic [3:0] OP_C2P  = 4'd4;
  localparam logic [3:0] OP_C2N  = 4'd5;
  localparam logic [3:0] OP_S0HH = 4'd6;
  localparam logic [3:0] OP_S0HL = 4'd7;
  localparam logic [3:0] OP_S0LL = 4'd8;
  localparam logic [3:0] OP_S1HH = 4'd9;
  localparam logic [3:0] OP_S1HL = 4'd10;
  localparam logic [3:0] OP_S1LL = 4'd11;
  localparam logic [3:0] OP_S2HH = 4'd12;
  localparam logic [3:0] OP_S2HL = 4'd13;
  localparam logic [3:0] OP_S2LL = 4'd14;

  localparam logic [1:0] PART_HH = 2'd0;
  localparam logic [1:0] PART_HL = 2'd1;
  localparam logic [1:0] PART_LL = 2'd2;

  localparam logic       CMD_VERTEX = 1'b0;
  localparam logic       CMD_FACE   = 1'b1;

  localparam logic [5:0] MUL_LAST  = 6'd29;
  localparam logic [5:0] SQRT_LAST = 6'd35;
  localparam logic [5:0] DIV_LAST  = 6'd47;
  localparam logic [3:0] DIV_FINAL = 4'd15;

  localparam logic [15:0] NORMAL_MAX = 16'd32767;

  typedef struct packed {
    logic       vtx_write;
    logic       face_load;
    logic [1:0] rd_sel;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       edge_en;
    logic       mul_en;
    logic       mul_clr;
    logic       mul_phase;
    logic [3:0] mul_op;
    logic       sqrt_en;
    logic       div_en;
    logic [1:0] div_comp;
    logic [3:0] div_step;
    logic       out_load;
  } cmd_t;

endpackage
`default_nettype wire

>>> design/tan_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tan_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tan_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [9:0]         vertex_slot;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic signed [15:0] coord_z;
  logic [9:0]         first_corner;
  logic [9:0]         second_corner;
  logic [9:0]         third_corner;

  modport source (output valid, command, vertex_slot, coord_x, coord_y, coord_z,
                  first_corner, second_corner, third_corner, input ready);
  modport sink (input valid, command, vertex_slot, coord_x, coord_y, coord_z,
                first_corner, second_corner, third_corner, output ready);
endinterface

interface tan_out_if;
  logic               valid;
  logic               ready;
  logic [32:0]        face_area;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;

  modport source (output valid, face_area, normal_x, normal_y, normal_z, input ready);
  modport sink (input valid, face_area, normal_x, normal_y, normal_z, output ready);
endinterface
`default_nettype wire

>>> design/tan_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tan_ram
// Generic simple dual-port RAM with registered read.
// ----------------------------------------------------------------------------
module tan_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> design/tan_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tan_ctrl
// Sequencer for vertex fetch, multiply, square root and divide phases.
// ----------------------------------------------------------------------------
module tan_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_command,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output tan_pkg::cmd_t    cmd
);

  tan_pkg::state_t state_r, state_nxt;
  logic [5:0]      cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;
  logic            out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 6'd1;
    case (state_r)
      tan_pkg::S_IDLE: begin
        cnt_nxt = '0;
        if (accept && in_command == tan_pkg::CMD_FACE) begin
          state_nxt = tan_pkg::S_RD0;
        end
      end
      tan_pkg::S_RD0:  state_nxt = tan_pkg::S_RD1;
      tan_pkg::S_RD1:  state_nxt = tan_pkg::S_RD2;
      tan_pkg::S_RD2:  state_nxt = tan_pkg::S_RD3;
      tan_pkg::S_RD3:  state_nxt = tan_pkg::S_EDGE;
      tan_pkg::S_EDGE: begin
        state_nxt = tan_pkg::S_MUL;
        cnt_nxt   = '0;
      end
      tan_pkg::S_MUL: begin
        if (cnt_r == tan_pkg::MUL_LAST) begin
          state_nxt = tan_pkg::S_SQRT;
          cnt_nxt   = '0;
        end
      end
      tan_pkg::S_SQRT: begin
        if (cnt_r == tan_pkg::SQRT_LAST) begin
          state_nxt = tan_pkg::S_DIV;
          cnt_nxt   = '0;
        end
      end
      tan_pkg::S_DIV: begin
        if (cnt_r == tan_pkg::DIV_LAST) begin
          state_nxt = tan_pkg::S_OUT;
          cnt_nxt   = '0;
        end
      end
      tan_pkg::S_OUT: begin
        cnt_nxt = '0;
        if (out_free) begin
          state_nxt = tan_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tan_pkg::S_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_ready      = (state_r == tan_pkg::S_IDLE);
    cmd.vtx_write = accept && in_command == tan_pkg::CMD_VERTEX;
    cmd.face_load = accept && in_command == tan_pkg::CMD_FACE;
    cmd.mul_phase = cnt_r[0];
    cmd.mul_op    = cnt_r[4:1];
    cmd.div_comp  = cnt_r[5:4];
    cmd.div_step  = cnt_r[3:0];
    case (state_r)
      tan_pkg::S_RD0: cmd.rd_sel = 2'd0;
      tan_pkg::S_RD1: begin
        cmd.rd_sel  = 2'd1;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = 2'd0;
      end
      tan_pkg::S_RD2: begin
        cmd.rd_sel  = 2'd2;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = 2'd1;
      end
      tan_pkg::S_RD3: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = 2'd2;
      end
      tan_pkg::S_EDGE: cmd.edge_en = 1'b1;
      tan_pkg::S_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_clr = (cnt_r == '0);
      end
      tan_pkg::S_SQRT: cmd.sqrt_en  = 1'b1;
      tan_pkg::S_DIV:  cmd.div_en   = 1'b1;
      tan_pkg::S_OUT:  cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tan_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/tan_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tan_dp
// Vertex store, shared multiplier, bit-serial square root and divider.
// ----------------------------------------------------------------------------
module tan_dp #(
  parameter int VERTEX_DEPTH = 1024
) (
  input  wire logic               clk,
  input  wire tan_pkg::cmd_t      cmd,
  input  wire logic [9:0]         vertex_slot,
  input  wire logic signed [15:0] coord_x,
  input  wire logic signed [15:0] coord_y,
  input  wire logic signed [15:0] coord_z,
  input  wire logic [9:0]         first_corner,
  input  wire logic [9:0]         second_corner,
  input  wire logic [9:0]         third_corner,
  output logic [32:0]             face_area,
  output logic signed [15:0]      normal_x,
  output logic signed [15:0]      normal_y,
  output logic signed [15:0]      normal_z
);

  localparam int AW = $clog2(VERTEX_DEPTH);

  logic [9:0]         corner_r [3];
  logic               corner_ok_r [3];
  logic               rd_ok_r;
  logic [47:0]        vert_r [3];
  logic signed [16:0] a_r [3];
  logic signed [16:0] b_r [3];
  logic signed [34:0] c_r [3];
  logic signed [35:0] prod_r;
  logic [71:0]        acc_r;
  logic [38:0]        rem_r;
  logic [35:0]        root_r;
  logic [36:0]        div_r;
  logic [14:0]        q_r;
  logic               sat_r;
  logic signed [15:0] norm_r [3];

  logic               slot_ok;
  logic [47:0]        rdata;
  logic signed [17:0] mul_a, mul_b;
  logic [1:0]         sq_comp, sq_part;
  logic [33:0]        sq_mag;
  logic [38:0]        rem_sh, trial;
  logic [33:0]        div_mag;
  logic [36:0]        div_sh;
  logic               q_bit;
  logic [14:0]        q_nxt;
  logic [15:0]        norm_val;

  function automatic logic [33:0] mag(input logic signed [34:0] v);
    logic signed [34:0] n;
    n = -v;
    return v[34] ? n[33:0] : v[33:0];
  endfunction

  function automatic logic signed [16:0] coord(input logic [47:0] v, input int i);
    logic [15:0] f;
    case (i)
      0:       f = v[47:32];
      1:       f = v[31:16];
      default: f = v[15:0];
    endcase
    return $signed({f[15], f});
  endfunction

  assign slot_ok = 32'(vertex_slot) < 32'(VERTEX_DEPTH);

  tan_ram #(.WIDTH(48), .DEPTH(VERTEX_DEPTH)) u_store (
    .clk   (clk),
    .we    (cmd.vtx_write && slot_ok),
    .waddr (AW'(vertex_slot)),
    .wdata ({coord_x, coord_y, coord_z}),
    .raddr (AW'(corner_r[cmd.rd_sel])),
    .rdata (rdata)
  );

  // squaring splits each 34-bit magnitude into two 17-bit halves
  always_comb begin
    sq_comp = 2'd0;
    sq_part = tan_pkg::PART_HH;
    mul_a   = '0;
    mul_b   = '0;
    case (cmd.mul_op)
      tan_pkg::OP_S0HH: begin sq_comp = 2'd0; sq_part = tan_pkg::PART_HH; end
      tan_pkg::OP_S0HL: begin sq_comp = 2'd0; sq_part = tan_pkg::PART_HL; end
      tan_pkg::OP_S0LL: begin sq_comp = 2'd0; sq_part = tan_pkg::PART_LL; end
      tan_pkg::OP_S1HH: begin sq_comp = 2'd1; sq_part = tan_pkg::PART_HH; end
      tan_pkg::OP_S1HL: begin sq_comp = 2'd1; sq_part = tan_pkg::PART_HL; end
      tan_pkg::OP_S1LL: begin sq_comp = 2'd1; sq_part = tan_pkg::PART_LL; end
      tan_pkg::OP_S2HH: begin sq_comp = 2'd2; sq_part = tan_pkg::PART_HH; end
      tan_pkg::OP_S2HL: begin sq_comp = 2'd2; sq_part = tan_pkg::PART_HL; end
      tan_pkg::OP_S2LL: begin sq_comp = 2'd2; sq_part = tan_pkg::PART_LL; end
      default: ;
    endcase
    sq_mag = mag(c_r[sq_comp]);
    case (cmd.mul_op)
      tan_pkg::OP_C0P: begin mul_a = 18'(a_r[1]); mul_b = 18'(b_r[2]); end
      tan_pkg::OP_C0N: begin mul_a = 18'(a_r[2]); mul_b = 18'(b_r[1]); end
      tan_pkg::OP_C1P: begin mul_a = 18'(a_r[2]); mul_b = 18'(b_r[0]); end
      tan_pkg::OP_C1N: begin mul_a = 18'(a_r[0]); mul_b = 18'(b_r[2]); end
      tan_pkg::OP_C2P: begin mul_a = 18'(a_r[0]); mul_b = 18'(b_r[1]); end
      tan_pkg::OP_C2N: begin mul_a = 18'(a_r[1]); mul_b = 18'(b_r[0]); end
      default: begin
        case (sq_part)
          tan_pkg::PART_HH: begin
            mul_a = $signed({1'b0, sq_mag[33:17]});
            mul_b = $signed({1'b0, sq_mag[33:17]});
          end
          tan_pkg::PART_HL: begin
            mul_a = $signed({1'b0, sq_mag[33:17]});
            mul_b = $signed({1'b0, sq_mag[16:0]});
          end
          default: begin
            mul_a = $signed({1'b0, sq_mag[16:0]});
            mul_b = $signed({1'b0, sq_mag[16:0]});
          end
        endcase
      end
    endcase
  end

  // square root, two radicand bits per step
  assign rem_sh = {rem_r[36:0], acc_r[71:70]};
  assign trial  = {1'b0, root_r, 2'b01};

  // restoring divide of |c| * 2^15 by the length
  assign div_mag  = mag(c_r[cmd.div_comp]);
  assign div_sh   = {div_r[35:0], 1'b0};
  assign q_bit    = div_sh >= {1'b0, root_r};
  assign q_nxt    = {q_r[13:0], q_bit};
  always_comb begin
    if (root_r == '0) begin
      norm_val = '0;
    end else if (sat_r) begin
      norm_val = tan_pkg::NORMAL_MAX;
    end else begin
      norm_val = {1'b0, q_nxt};
    end
    if (c_r[cmd.div_comp][34]) begin
      norm_val = -norm_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.face_load) begin
      corner_r[0]    <= first_corner;
      corner_r[1]    <= second_corner;
      corner_r[2]    <= third_corner;
      corner_ok_r[0] <= 32'(first_corner) < 32'(VERTEX_DEPTH);
      corner_ok_r[1] <= 32'(second_corner) < 32'(VERTEX_DEPTH);
      corner_ok_r[2] <= 32'(third_corner) < 32'(VERTEX_DEPTH);
    end
    rd_ok_r <= corner_ok_r[cmd.rd_sel];

    // a corner beyond the store reads as the zero vertex
    if (cmd.cap_en) begin
      vert_r[cmd.cap_sel] <= rd_ok_r ? rdata : '0;
    end

    if (cmd.edge_en) begin
      for (int i = 0; i < 3; i++) begin
        a_r[i] <= coord(vert_r[1], i) - coord(vert_r[0], i);
        b_r[i] <= coord(vert_r[2], i) - coord(vert_r[0], i);
      end
    end

    if (cmd.mul_en) begin
      if (!cmd.mul_phase) begin
        prod_r <= mul_a * mul_b;
        if (cmd.mul_clr) begin
          acc_r  <= '0;
          rem_r  <= '0;
          root_r <= '0;
        end
      end else begin
        case (cmd.mul_op)
          tan_pkg::OP_C0P: c_r[0] <= 35'(prod_r);
          tan_pkg::OP_C0N: c_r[0] <= c_r[0] - 35'(prod_r);
          tan_pkg::OP_C1P: c_r[1] <= 35'(prod_r);
          tan_pkg::OP_C1N: c_r[1] <= c_r[1] - 35'(prod_r);
          tan_pkg::OP_C2P: c_r[2] <= 35'(prod_r);
          tan_pkg::OP_C2N: c_r[2] <= c_r[2] - 35'(prod_r);
          default: begin
            case (sq_part)
              tan_pkg::PART_HH: acc_r <= acc_r + ({36'b0, prod_r} << 34);
              tan_pkg::PART_HL: acc_r <= acc_r + ({36'b0, prod_r} << 18);
              default:          acc_r <= acc_r + {36'b0, prod_r};
            endcase
          end
        endcase
      end
    end

    if (cmd.sqrt_en) begin
      acc_r <= {acc_r[69:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[34:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[34:0], 1'b0};
      end
    end

    if (cmd.div_en) begin
      if (cmd.div_step == '0) begin
        sat_r <= {2'b00, div_mag} >= root_r;
        div_r <= {3'b000, div_mag};
        q_r   <= '0;
      end else begin
        div_r <= q_bit ? div_sh - {1'b0, root_r} : div_sh;
        q_r   <= q_nxt;
        if (cmd.div_step == tan_pkg::DIV_FINAL) begin
          norm_r[cmd.div_comp] <= norm_val;
        end
      end
    end

    if (cmd.out_load) begin
      face_area <= root_r[33:1];
      normal_x  <= norm_r[0];
      normal_y  <= norm_r[1];
      normal_z  <= norm_r[2];
    end
  end

endmodule
`default_nettype wire

>>> design/triangle_area_normal.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_area_normal
// Triangle face area and unit normal over a stored vertex table.
// ----------------------------------------------------------------------------
// A vertex write request (command 0) stores one Q7.8 vertex and gives no
// result. A face request (command 1) reads its three corners from the
// vertex RAM one after another, forms both edges, builds the cross product
// and its squared length on one shared 18x18 multiplier (15 products), takes
// the floor square root two radicand bits per cycle and then divides each
// component by the length one quotient bit per cycle. No new request is
// taken until a face is done; the result sits in an output register, so a
// new request is taken while it waits. The area is the root halved, in
// Q.16; the normal is Q1.15, truncated toward zero and clamped to +/-32767,
// and a zero-length cross product yields all zeros. Vertex slots at or
// beyond VERTEX_DEPTH are ignored on write and read as zero.
module triangle_area_normal #(
  parameter int VERTEX_DEPTH = 1024
) (
  input wire logic clk,
  input wire logic rst_n,
  tan_in_if.sink   in_ch,
  tan_out_if.source out_ch
);

  tan_pkg::cmd_t cmd;

  tan_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cmd        (cmd)
  );

  tan_dp #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .vertex_slot   (in_ch.vertex_slot),
    .coord_x       (in_ch.coord_x),
    .coord_y       (in_ch.coord_y),
    .coord_z       (in_ch.coord_z),
    .first_corner  (in_ch.first_corner),
    .second_corner (in_ch.second_corner),
    .third_corner  (in_ch.third_corner),
    .face_area     (out_ch.face_area),
    .normal_x      (out_ch.normal_x),
    .normal_y      (out_ch.normal_y),
    .normal_z      (out_ch.normal_z)
  );

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the triangle area and normal block: vertex write
// and face requests are driven with random gaps, results are compared against
// an area/normal predictor holding its own copy of the vertex table.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    logic [32:0]        area;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
  } face_result_t;

  typedef struct {
    logic               cmd;
    logic [9:0]         slot;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [9:0]         c0;
    logic [9:0]         c1;
    logic [9:0]         c2;
    logic               has_typed;
    face_result_t       typed;
  } request_t;

  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  tan_in_if  in_ch();
  tan_out_if out_ch();

  triangle_area_normal dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  logic signed [15:0] vtx_x [1024];
  logic signed [15:0] vtx_y [1024];
  logic signed [15:0] vtx_z [1024];
  bit                 vtx_written [1024];
  face_result_t       pending_faces [$];
  request_t           directed [$];
  int                 fails = 0;
  int                 cycles = 0;
  int                 stall_left = 0;
  bit                 calm;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] unit_part(longint comp, logic [35:0] len);
    logic [63:0] mag;
    logic [63:0] q;
    mag = comp < 0 ? -comp : comp;
    if (len == 0) return 16'd0;
    q = (mag << 15) / len;
    if (q > 64'(tan_pkg::NORMAL_MAX)) q = 64'(tan_pkg::NORMAL_MAX);
    return comp < 0 ? 16'(-q) : 16'(q);
  endfunction

  function automatic face_result_t face_predict(logic [9:0] i0, logic [9:0] i1,
                                                logic [9:0] i2);
    longint      ax, ay, az, bx, by, bz, cx, cy, cz;
    logic [69:0] m0, m1, m2;
    logic [69:0] sumsq;
    logic [35:0] root;
    logic [35:0] trial;
    face_result_t r;
    ax = longint'(vtx_x[i1]) - vtx_x[i0];
    ay = longint'(vtx_y[i1]) - vtx_y[i0];
    az = longint'(vtx_z[i1]) - vtx_z[i0];
    bx = longint'(vtx_x[i2]) - vtx_x[i0];
    by = longint'(vtx_y[i2]) - vtx_y[i0];
    bz = longint'(vtx_z[i2]) - vtx_z[i0];
    cx = ay * bz - az * by;
    cy = az * bx - ax * bz;
    cz = ax * by - ay * bx;
    // squares exceed 64 bits, so sum magnitudes at full width
    m0 = 70'(cx < 0 ? -cx : cx);
    m1 = 70'(cy < 0 ? -cy : cy);
    m2 = 70'(cz < 0 ? -cz : cz);
    sumsq = m0 * m0 + m1 * m1 + m2 * m2;
    root = 0;
    for (int b = 35; b >= 0; b--) begin
      trial = root | (36'd1 << b);
      if (72'(trial) * 72'(trial) <= 72'(sumsq)) root = trial;
    end
    r.area = 33'(root >> 1);
    r.nx = unit_part(cx, root);
    r.ny = unit_part(cy, root);
    r.nz = unit_part(cz, root);
    return r;
  endfunction

  // result side: random stall bursts, compare against oldest pending face
  always @(posedge clk) begin
    face_result_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_faces.size() == 0) begin
          $error("result with no face pending");
          fails++;
        end else begin
          e = pending_faces.pop_front();
          if (out_ch.face_area !== e.area) begin
            $error("face_area exp %0d got %0d", e.area, out_ch.face_area); fails++;
          end
          if (out_ch.normal_x !== e.nx) begin
            $error("normal_x exp %0d got %0d", e.nx, out_ch.normal_x); fails++;
          end
          if (out_ch.normal_y !== e.ny) begin
            $error("normal_y exp %0d got %0d", e.ny, out_ch.normal_y); fails++;
          end
          if (out_ch.normal_z !== e.nz) begin
            $error("normal_z exp %0d got %0d", e.nz, out_ch.normal_z); fails++;
          end
        end
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 5) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send(request_t rq);
    face_result_t p;
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= rq.cmd;
    in_ch.vertex_slot   <= rq.slot;
    in_ch.coord_x       <= rq.x;
    in_ch.coord_y       <= rq.y;
    in_ch.coord_z       <= rq.z;
    in_ch.first_corner  <= rq.c0;
    in_ch.second_corner <= rq.c1;
    in_ch.third_corner  <= rq.c2;
    do @(posedge clk); while (!in_ch.ready);
    if (rq.cmd == tan_pkg::CMD_VERTEX) begin
      vtx_x[rq.slot] = rq.x;
      vtx_y[rq.slot] = rq.y;
      vtx_z[rq.slot] = rq.z;
      vtx_written[rq.slot] = 1'b1;
    end else begin
      p = face_predict(rq.c0, rq.c1, rq.c2);
      if (rq.has_typed) begin
        if (p.area !== rq.typed.area || p.nx !== rq.typed.nx ||
            p.ny !== rq.typed.ny || p.nz !== rq.typed.nz)
          p = rq.typed;
      end
      pending_faces.push_back(p);
    end
  endtask

  function automatic request_t vertex_req(int slot, int x, int y, int z);
    request_t r;
    r = '{default: 0};
    r.cmd = tan_pkg::CMD_VERTEX; r.slot = 10'(slot);
    r.x = 16'(x); r.y = 16'(y); r.z = 16'(z);
    r.c0 = 10'($urandom); r.c1 = 10'($urandom); r.c2 = 10'($urandom);
    return r;
  endfunction

  function automatic request_t face_req(int i0, int i1, int i2, bit typed = 0,
                                       longint area = 0, int nx = 0, int ny = 0,
                                       int nz = 0);
    request_t r;
    r = '{default: 0};
    r.cmd = tan_pkg::CMD_FACE; r.c0 = 10'(i0); r.c1 = 10'(i1); r.c2 = 10'(i2);
    r.slot = 10'($urandom); r.x = 16'($urandom); r.y = 16'($urandom);
    r.z = 16'($urandom);
    r.has_typed = typed;
    r.typed.area = 33'(area); r.typed.nx = 16'(nx); r.typed.ny = 16'(ny);
    r.typed.nz = 16'(nz);
    return r;
  endfunction

  function automatic int written_slot();
    int s;
    do s = $urandom_range(0, 1023); while (!vtx_written[s]);
    return s;
  endfunction

  initial begin
    request_t rq;
    int s;
    calm = 0;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.command = 0;
    in_ch.vertex_slot = 0;
    in_ch.coord_x = 0;
    in_ch.coord_y = 0;
    in_ch.coord_z = 0;
    in_ch.first_corner = 0;
    in_ch.second_corner = 0;
    in_ch.third_corner = 0;
    foreach (vtx_written[i]) vtx_written[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unit right triangle in xy: c = (0,0,65536), L = 65536
    directed.push_back(vertex_req(0, 0, 0, 0));
    directed.push_back(vertex_req(1, 256, 0, 0));
    directed.push_back(vertex_req(2, 0, 256, 0));
    directed.push_back(face_req(0, 1, 2, 1, 32768, 0, 0, 32767));
    directed.push_back(face_req(0, 2, 1, 1, 32768, 0, 0, -32767));
    // degenerate: repeated corner gives zero everything
    directed.push_back(face_req(1, 1, 2, 1, 0, 0, 0, 0));
    directed.push_back(face_req(0, 0, 0, 1, 0, 0, 0, 0));
    // coordinate extremes
    directed.push_back(vertex_req(1023, -32768, -32768, -32768));
    directed.push_back(vertex_req(1022, 32767, -32768, 32767));
    directed.push_back(vertex_req(1021, -32768, 32767, 32767));
    directed.push_back(vertex_req(512, 32767, 32767, -32768));
    directed.push_back(face_req(1023, 1022, 1021));
    directed.push_back(face_req(1021, 512, 1023));
    directed.push_back(face_req(512, 1022, 1021));
    // collinear points
    directed.push_back(vertex_req(3, 512, 0, 0));
    directed.push_back(face_req(0, 1, 3, 1, 0, 0, 0, 0));
    // tiny face where the floored root can push a quotient above one
    directed.push_back(vertex_req(4, 1, 0, 0));
    directed.push_back(vertex_req(5, 0, 1, 1));
    directed.push_back(face_req(0, 4, 5));
    directed.push_back(vertex_req(6, -1, 2, -3));
    directed.push_back(face_req(5, 6, 4));
    foreach (directed[i]) send(directed[i]);

    for (int n = 0; n < 550; n++) begin
      if (n > 480) calm = 1;
      if ($urandom_range(0, 2) == 0) begin
        s = $urandom_range(0, 99) < 70 ? $urandom_range(0, 31) : $urandom_range(0, 1023);
        case ($urandom_range(0, 3))
          0: rq = vertex_req(s, $urandom_range(0, 15) - 8, $urandom_range(0, 15) - 8,
                             $urandom_range(0, 15) - 8);
          default: rq = vertex_req(s, $urandom, $urandom, $urandom);
        endcase
      end else begin
        rq = face_req(written_slot(), written_slot(), written_slot());
      end
      send(rq);
    end
    in_ch.valid <= 1'b0;

    while (pending_faces.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
